// ----- src/gcsc_pkg.sv -----
// Shared types and constants of the grid cell slot cache.
package gcsc_pkg;

	// Coordinate and dimension widths
	localparam int CW     = 4;
	localparam int DIM_W  = 5;
	localparam int COORD_W = 3 * CW;

	// Partial index z*dim_y+y and full index (z*dim_y+y)*dim_x+x, sized for any 5-bit dimension
	localparam int ZY_W  = 10;
	localparam int OFF_W = 14;

	// Stream and configuration widths
	localparam int IN_W    = 16;
	localparam int CFG_I_W = 2;

	// Configuration register indexes
	localparam logic [CFG_I_W-1:0] REG_DIM_X = 2'd0;
	localparam logic [CFG_I_W-1:0] REG_DIM_Y = 2'd1;
	localparam logic [CFG_I_W-1:0] REG_DIM_Z = 2'd2;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAP,
		ST_SLOT,
		ST_CHECK,
		ST_HIT_WR,
		ST_MISS_WR,
		ST_FIN
	} gcsc_state_t;

endpackage

// ----- src/grid_cell_slot_cache.sv -----
// Top level of the grid cell slot cache: cell map, slot table and replacement queue.
//
// Maps a 3D cell coordinate onto one of SLOTS slots. After reset the block runs a clearing
// pass over max(MAX_DIM**3, SLOTS) addresses that invalidates the cell map
// and sets the replacement queue to identity; no item is accepted during it, configuration
// writes are. Items are then handled one at a time. The steps are dependent reads in
// memories with one registered read port each: the cell map read gives the slot number,
// which addresses the slot table read, followed by a write-back for the queue swap or slot
// fill. An out-of-range request stops before the slot table read, and a hit whose slot sits
// just behind the queue head needs no write-back. A finished item waits in an output
// register, so a new item is accepted while the previous result is still pending.
module grid_cell_slot_cache
	import gcsc_pkg::*;
#(
	parameter int SLOTS   = 64,
	parameter int MAX_DIM = 16,
	localparam int SW     = $clog2(SLOTS),
	localparam int OUT_BITS = SW + 2 + 3 * CW + 1,
	localparam int OUT_W  = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_I_W-1:0]   cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	// request items
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [IN_W-1:0]      s_axis_tdata,  // cell_x, cell_y, cell_z, zero pad
	// result items
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [OUT_W-1:0]     m_axis_tdata   // slot, hit, evicted, evicted_x, evicted_y,
	                                            // evicted_z, range_error, zero pad
);

	localparam int MAP_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
	localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam int MAP_DW    = 1 + SW;
	localparam int SL_DW     = 1 + COORD_W + SW;
	localparam int CLR_N     = (MAP_DEPTH > SLOTS) ? MAP_DEPTH : SLOTS;
	localparam int CLR_W     = $clog2(CLR_N);
	localparam int DIM_RST   = (16 > MAX_DIM) ? MAX_DIM : 16;

	gcsc_state_t state_q, state_d;

	logic [CLR_W-1:0]   clr_q;
	logic [SW-1:0]      head_q;
	logic [DIM_W-1:0]   dim_x_q, dim_y_q, dim_z_q;
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;

	// per-item working registers
	logic [COORD_W-1:0] coord_q;
	logic [ZY_W-1:0]    zy_q;
	logic               rng_q;
	logic [MAP_AW-1:0]  off_q;
	logic [SW-1:0]      id_q;
	logic               mvalid_q;
	logic [SW-1:0]      victim_q;
	logic [SW-1:0]      pos_q;

	// result fields of the item in flight
	logic [SW-1:0]      res_slot_q;
	logic               res_hit_q;
	logic               res_ev_q;
	logic [COORD_W-1:0] res_ecoord_q;
	logic               res_rng_q;

	// memory ports
	logic              map_we;
	logic [MAP_AW-1:0] map_waddr, map_raddr;
	logic [MAP_DW-1:0] map_wdata, map_rdata;
	logic              slot_we;
	logic [SW-1:0]     slot_waddr, slot_raddr;
	logic [SL_DW-1:0]  slot_wdata, slot_rdata;
	logic              q_we;
	logic [SW-1:0]     q_waddr, q_raddr;
	logic [SW-1:0]     q_wdata, q_rdata;

	logic               in_accept;
	logic               out_load;
	logic               head_adv;
	logic [CW-1:0]      in_x, in_y, in_z;
	logic               in_rng;
	logic [ZY_W-1:0]    zy_w;
	logic [OFF_W-1:0]   off_w;
	logic               off_bad;
	logic               sl_occ;
	logic [COORD_W-1:0] sl_coord;
	logic [SW-1:0]      sl_qpos;
	logic [SW-1:0]      qpos_next;
	logic               hit_w;
	logic               swap_w;
	logic               clr_last;
	logic               clr_map;
	logic               clr_slot;
	logic [DIM_W-1:0]   cfg_dim;
	logic [OUT_W-1:0]   out_next;

	gcsc_ram #(.W(MAP_DW), .D(MAP_DEPTH)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	gcsc_ram #(.W(SL_DW), .D(SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	gcsc_ram #(.W(SW), .D(SLOTS)) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	// Unpack request and check range
	assign in_x   = s_axis_tdata[CW-1:0];
	assign in_y   = s_axis_tdata[2*CW-1:CW];
	assign in_z   = s_axis_tdata[3*CW-1:2*CW];
	assign in_rng = ({1'b0, in_x} >= dim_x_q) || ({1'b0, in_y} >= dim_y_q) ||
	                ({1'b0, in_z} >= dim_z_q);
	assign zy_w   = ZY_W'(in_z) * ZY_W'(dim_y_q) + ZY_W'(in_y);

	// Finish the linear cell index
	assign off_w   = OFF_W'(zy_q) * OFF_W'(dim_x_q) + OFF_W'(coord_q[CW-1:0]);
	assign off_bad = rng_q || (off_w >= MAP_DEPTH);

	// Slot table entry fields
	assign sl_occ    = slot_rdata[SL_DW-1];
	assign sl_coord  = slot_rdata[SW +: COORD_W];
	assign sl_qpos   = slot_rdata[SW-1:0];
	assign qpos_next = (sl_qpos == SW'(SLOTS - 1)) ? '0 : sl_qpos + 1'b1;
	assign hit_w     = mvalid_q && sl_occ && (sl_coord == coord_q);
	assign swap_w    = (qpos_next != head_q);

	// Clearing sweep controls
	assign clr_last = (clr_q == CLR_W'(CLR_N - 1));
	assign clr_map  = ({1'b0, clr_q} < (CLR_W + 1)'(MAP_DEPTH));
	assign clr_slot = ({1'b0, clr_q} < (CLR_W + 1)'(SLOTS));

	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Saturate a written dimension
	assign cfg_dim = (cfg_data > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg_data;

	// Pack the result item
	always_comb begin
		out_next = '0;
		out_next[SW-1:0]               = res_slot_q;
		out_next[SW]                   = res_hit_q;
		out_next[SW+1]                 = res_ev_q;
		out_next[SW+2 +: COORD_W]      = res_ecoord_q;
		out_next[SW+2+COORD_W]         = res_rng_q;
	end

	// Next state and memory controls
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		head_adv      = 1'b0;
		map_we        = 1'b0;
		map_waddr     = off_q;
		map_wdata     = {1'b1, victim_q};
		map_raddr     = MAP_AW'(off_w);
		slot_we       = 1'b0;
		slot_waddr    = victim_q;
		slot_wdata    = {1'b1, coord_q, sl_qpos};
		slot_raddr    = victim_q;
		q_we          = 1'b0;
		q_waddr       = head_q;
		q_wdata       = id_q;
		q_raddr       = head_q;
		unique case (state_q)
			ST_CLEAR: begin
				map_we     = clr_map;
				map_waddr  = clr_q[MAP_AW-1:0];
				map_wdata  = '0;
				slot_we    = clr_slot;
				slot_waddr = clr_q[SW-1:0];
				slot_wdata = {1'b0, {COORD_W{1'b0}}, clr_q[SW-1:0]};
				q_we       = clr_slot;
				q_waddr    = clr_q[SW-1:0];
				q_wdata    = clr_q[SW-1:0];
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_MAP;
				end
			end
			ST_MAP: begin
				// map read and queue head read go out together
				state_d = off_bad ? ST_FIN : ST_SLOT;
			end
			ST_SLOT: begin
				slot_raddr = map_rdata[SW-1:0];
				state_d    = ST_CHECK;
			end
			ST_CHECK: begin
				// fetch the victim entry; on a swap move the hit slot to the head
				if (hit_w) begin
					if (swap_w) begin
						slot_we    = 1'b1;
						slot_waddr = id_q;
						slot_wdata = {sl_occ, sl_coord, head_q};
						q_we       = 1'b1;
						q_waddr    = head_q;
						q_wdata    = id_q;
						state_d    = ST_HIT_WR;
					end else begin
						state_d = ST_FIN;
					end
				end else begin
					state_d = ST_MISS_WR;
				end
			end
			ST_HIT_WR: begin
				slot_we    = 1'b1;
				slot_waddr = victim_q;
				slot_wdata = {sl_occ, sl_coord, pos_q};
				q_we       = 1'b1;
				q_waddr    = pos_q;
				q_wdata    = victim_q;
				head_adv   = 1'b1;
				state_d    = ST_FIN;
			end
			ST_MISS_WR: begin
				slot_we    = 1'b1;
				slot_waddr = victim_q;
				slot_wdata = {1'b1, coord_q, sl_qpos};
				map_we     = 1'b1;
				head_adv   = 1'b1;
				state_d    = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			head_q      <= '0;
			out_valid_q <= 1'b0;
			dim_x_q     <= DIM_W'(DIM_RST);
			dim_y_q     <= DIM_W'(DIM_RST);
			dim_z_q     <= DIM_W'(DIM_RST);
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			// advance the queue head with wrap
			if (head_adv) begin
				head_q <= (head_q == SW'(SLOTS - 1)) ? '0 : head_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_DIM_X: dim_x_q <= cfg_dim;
					REG_DIM_Y: dim_y_q <= cfg_dim;
					REG_DIM_Z: dim_z_q <= cfg_dim;
					default: ;
				endcase
			end
		end
	end

	// Item payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			coord_q <= {in_z, in_y, in_x};
			zy_q    <= zy_w;
			rng_q   <= in_rng;
		end
		if (state_q == ST_MAP) begin
			off_q    <= MAP_AW'(off_w);
			victim_q <= q_rdata;
			if (off_bad) begin
				res_slot_q   <= '0;
				res_hit_q    <= 1'b0;
				res_ev_q     <= 1'b0;
				res_ecoord_q <= '0;
				res_rng_q    <= 1'b1;
			end
		end
		if (state_q == ST_SLOT) begin
			id_q     <= map_rdata[SW-1:0];
			mvalid_q <= map_rdata[MAP_DW-1];
			victim_q <= q_rdata;
		end
		if (state_q == ST_CHECK) begin
			pos_q <= sl_qpos;
			if (hit_w) begin
				res_slot_q   <= id_q;
				res_hit_q    <= 1'b1;
				res_ev_q     <= 1'b0;
				res_ecoord_q <= '0;
				res_rng_q    <= 1'b0;
			end
		end
		if (state_q == ST_MISS_WR) begin
			res_slot_q   <= victim_q;
			res_hit_q    <= 1'b0;
			res_ev_q     <= sl_occ;
			res_ecoord_q <= sl_occ ? sl_coord : '0;
			res_rng_q    <= 1'b0;
		end
		if (out_load) begin
			out_data_q <= out_next;
		end
	end

	// A result appears only out of the finishing state
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result raised outside the finishing state");

	// The queue head moves only in a write-back state
	a_head_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q != $past(head_q)) |->
		($past(state_q == ST_HIT_WR) || $past(state_q == ST_MISS_WR)))
		else $error("queue head moved outside a write-back");

	// A flagged request never reports a hit or an eviction
	a_rng_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q[SW+2+COORD_W] |-> !out_data_q[SW] && !out_data_q[SW+1])
		else $error("range error reported with hit or eviction");

endmodule

// ----- src/gcsc_ram.sv -----
// Generic synchronous RAM: one write port, one read port with registered, read-first data.
module gcsc_ram #(
	parameter int W = 8,
	parameter int D = 16,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	// Write and read; a read of the written entry returns the old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
